// ----- hw/rtl/dotq_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dotq_pkg
// shared types and codes for the deadline ordered task queue
// ----------------------------------------------------------------------------
package dotq_pkg;

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_REMOVE = 1'b1;

    localparam logic [1:0] STATUS_DONE      = 2'd0;
    localparam logic [1:0] STATUS_FULL      = 2'd1;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

    typedef struct packed {
        logic        func;
        logic [31:0] task_id;
        logic [31:0] deadline;
        logic        task_kind;
        logic [31:0] release_at;
        logic [31:0] finished_at;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] out_id;
        logic [31:0] out_deadline;
        logic        out_kind;
        logic [31:0] out_release;
        logic [31:0] out_finished;
        logic [4:0]  count;
        logic        front_valid;
        logic [31:0] front_id;
        logic [31:0] front_deadline;
    } rsp_t;

    typedef struct packed {
        logic [31:0] task_id;
        logic [31:0] deadline;
        logic        task_kind;
        logic [31:0] release_at;
        logic [31:0] finished_at;
    } slot_t;

endpackage
`default_nettype wire

// ----- hw/rtl/deadline_ordered_task_queue_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// deadline_ordered_task_queue_top
// earliest-deadline-first ready queue of task records
// ----------------------------------------------------------------------------
// usage
//   in channel (in_valid / in_stall / in_req) carries one request: insert a
//   task record or remove a task by id. out channel (out_valid / out_stall /
//   out_rsp) returns exactly one response per request, in request order
// flow and throughput
//   a request enters a two-entry queue, then the sorted table handles it:
//   compare every slot in parallel and shift; the response is registered.
//   one request per cycle sustained while out_stall stays low
// reset
//   the table empties at once (count cleared); slot contents are not reset
// stalls
//   a stalled response holds in the output register; the table stops, the
//   request queue fills and then in_stall rises
// ----------------------------------------------------------------------------
module deadline_ordered_task_queue_top
    import dotq_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  wire  logic clk,
    input  wire  logic rst_n,
    input  wire  logic in_valid,
    output logic       in_stall,
    input  wire  req_t in_req,
    output logic       out_valid,
    input  wire  logic out_stall,
    output rsp_t       out_rsp
);

    // queue between front and back
    logic q_valid;
    logic q_take;
    req_t q_req;

    dotq_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_req   (in_req),
        .q_valid  (q_valid),
        .q_take   (q_take),
        .q_req    (q_req)
    );

    dotq_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_take    (q_take),
        .q_req     (q_req),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_rsp   (out_rsp)
    );

`ifndef SYNTH
    // a stalled response stays put
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_rsp))
        else $error("stalled response changed");
    // front valid matches count
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_rsp.front_valid == (out_rsp.count != 5'd0)))
        else $error("front_valid disagrees with count");
    // refused or missing results carry no record
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_rsp.status != STATUS_DONE |-> out_rsp.out_id == '0)
        else $error("failed request returned a record");
`endif

endmodule
`default_nettype wire

// ----- hw/rtl/dotq_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dotq_front
// two-entry request queue that decouples the input from the sorted table
// ----------------------------------------------------------------------------
module dotq_front
    import dotq_pkg::*;
(
    input  wire  logic clk,
    input  wire  logic rst_n,
    input  wire  logic in_valid,
    output logic       in_stall,
    input  wire  req_t in_req,
    output logic       q_valid,
    input  wire  logic q_take,
    output req_t       q_req
);

    req_t       buf_reg [2];
    logic       rd_ptr_reg;
    logic       wr_ptr_reg;
    logic [1:0] fill_reg;
    logic       push;
    logic       pop;

    assign in_stall = (fill_reg == 2'd2);
    assign push     = in_valid && !in_stall;
    assign q_valid  = (fill_reg != 2'd0);
    assign pop      = q_valid && q_take;
    assign q_req    = buf_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            fill_reg <= fill_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            buf_reg[wr_ptr_reg] <= in_req;
    end

endmodule
`default_nettype wire

// ----- hw/rtl/dotq_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dotq_back
// sorted slot array: parallel compare, shift insert or close gap
// ----------------------------------------------------------------------------
module dotq_back
    import dotq_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  wire  logic clk,
    input  wire  logic rst_n,
    input  wire  logic q_valid,
    output logic       q_take,
    input  wire  req_t q_req,
    output logic       out_valid,
    input  wire  logic out_stall,
    output rsp_t       out_rsp
);

    localparam int CW = $clog2(DEPTH + 1);

    slot_t          slot_reg [DEPTH];
    logic  [CW-1:0] count_reg;
    logic  [CW-1:0] count_next;
    logic           valid_reg;
    rsp_t           rsp_reg;
    rsp_t           rsp_next;

    logic [DEPTH-1:0] occ;
    logic [DEPTH-1:0] ge;
    logic [DEPTH-1:0] hit;
    logic [DEPTH-1:0] hit_first;
    logic [DEPTH-1:0] after_hit;
    logic             found;
    logic             full;
    logic             fire;
    slot_t            new_slot;
    slot_t            got;
    slot_t            front;

    assign q_take    = !valid_reg || !out_stall;
    assign fire      = q_valid && q_take;
    assign out_valid = valid_reg;
    assign out_rsp   = rsp_reg;
    assign full      = (count_reg == CW'(DEPTH));

    assign new_slot.task_id     = q_req.task_id;
    assign new_slot.deadline    = q_req.deadline;
    assign new_slot.task_kind   = q_req.task_kind;
    assign new_slot.release_at  = q_req.release_at;
    assign new_slot.finished_at = q_req.finished_at;

    // per-slot compares, then a prefix scan for the first hit
    always_comb
    begin
        logic seen;
        for (int i = 0; i < DEPTH; i++)
        begin
            occ[i] = (CW'(i) < count_reg);
            ge[i]  = occ[i] && (slot_reg[i].deadline >= q_req.deadline);
            hit[i] = occ[i] && (slot_reg[i].task_id == q_req.task_id);
        end
        seen = 1'b0;
        got  = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            hit_first[i] = hit[i] && !seen;
            if (hit_first[i])
                got = slot_reg[i];
            seen         = seen || hit[i];
            after_hit[i] = seen;
        end
        found = seen;
    end

    always_comb
    begin
        count_next = count_reg;
        if (q_req.func == FUNC_INSERT && !full)
            count_next = count_reg + 1'b1;
        else if (q_req.func == FUNC_REMOVE && found)
            count_next = count_reg - 1'b1;
    end

    // front after the operation
    always_comb
    begin
        front = slot_reg[0];
        if (q_req.func == FUNC_INSERT && !full && (ge[0] || !occ[0]))
            front = new_slot;
        else if (q_req.func == FUNC_REMOVE && found && hit_first[0])
            front = slot_reg[1];
    end

    always_comb
    begin
        rsp_next       = '0;
        rsp_next.count = 5'(count_next);
        if (q_req.func == FUNC_INSERT)
        begin
            rsp_next.status = full ? STATUS_FULL : STATUS_DONE;
        end
        else if (found)
        begin
            rsp_next.status       = STATUS_DONE;
            rsp_next.out_id       = got.task_id;
            rsp_next.out_deadline = got.deadline;
            rsp_next.out_kind     = got.task_kind;
            rsp_next.out_release  = got.release_at;
            rsp_next.out_finished = got.finished_at;
        end
        else
        begin
            rsp_next.status = STATUS_NOT_FOUND;
        end
        if (count_next != '0)
        begin
            rsp_next.front_valid    = 1'b1;
            rsp_next.front_id       = front.task_id;
            rsp_next.front_deadline = front.deadline;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
                count_reg <= count_next;
            if (fire)
                valid_reg <= 1'b1;
            else if (!out_stall)
                valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
            rsp_reg <= rsp_next;
    end

    // each slot takes its own value, its left neighbor, the new record or its right one
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_slot
        always_ff @(posedge clk)
        begin
            if (fire)
            begin
                if (q_req.func == FUNC_INSERT && !full)
                begin
                    if (i > 0 && ge[(i > 0) ? i - 1 : 0])
                        slot_reg[i] <= slot_reg[(i > 0) ? i - 1 : 0];
                    else if (ge[i] || (CW'(i) == count_reg))
                        slot_reg[i] <= new_slot;
                end
                else if (q_req.func == FUNC_REMOVE && after_hit[i] && i < DEPTH - 1)
                begin
                    slot_reg[i] <= slot_reg[(i < DEPTH - 1) ? i + 1 : i];
                end
            end
        end
    end

endmodule
`default_nettype wire

// ----- sim/tb_deadline_ordered_task_queue_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_deadline_ordered_task_queue_top
// self-checking bench for the earliest-deadline-first task queue: a driver
// feeds requests from a queue, a monitor compares each response with a
// sorted-table predictor, random gaps on both channels
// ----------------------------------------------------------------------------
module tb_deadline_ordered_task_queue_top;
    import dotq_pkg::*;

    localparam int QDEPTH    = 16;
    localparam int MAX_CYCLES = 200000;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    req_t in_req;
    logic out_valid;
    logic out_stall;
    rsp_t out_rsp;

    deadline_ordered_task_queue_top #(.DEPTH(QDEPTH)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_req    (in_req),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_rsp   (out_rsp)
    );

    // requests waiting for the driver, responses waiting for the monitor
    req_t pending_reqs[$];
    rsp_t expected_rsps[$];
    int   error_count;
    int   cycle_count;
    bit   hold_sender;
    bit   stimulus_done;

    int   send_gap;
    int   recv_gap;
    bit   in_valid_next_clear;
    logic in_stall_q;

    // predictor copy of the sorted table
    slot_t table_slots[QDEPTH];
    int    table_count;

    // ids drawn from a small pool so removes often hit
    logic [31:0] id_pool[8];

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // gap length: mostly zero or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    // apply one request to the table copy and give the response it causes
    function automatic rsp_t queue_apply(req_t r);
        rsp_t rsp;
        int   pos;
        bit   found;
        rsp = '0;
        if (r.func == FUNC_INSERT)
        begin
            if (table_count >= QDEPTH)
                rsp.status = STATUS_FULL;
            else
            begin
                pos = 0;
                while (pos < table_count && table_slots[pos].deadline < r.deadline)
                    pos++;
                for (int i = table_count; i > pos; i--)
                    table_slots[i] = table_slots[i - 1];
                table_slots[pos] = '{r.task_id, r.deadline, r.task_kind,
                                     r.release_at, r.finished_at};
                table_count++;
                rsp.status = STATUS_DONE;
            end
        end
        else
        begin
            found = 1'b0;
            pos = 0;
            while (pos < table_count)
            begin
                if (table_slots[pos].task_id == r.task_id)
                begin
                    found = 1'b1;
                    break;
                end
                pos++;
            end
            if (!found)
                rsp.status = STATUS_NOT_FOUND;
            else
            begin
                rsp.status       = STATUS_DONE;
                rsp.out_id       = table_slots[pos].task_id;
                rsp.out_deadline = table_slots[pos].deadline;
                rsp.out_kind     = table_slots[pos].task_kind;
                rsp.out_release  = table_slots[pos].release_at;
                rsp.out_finished = table_slots[pos].finished_at;
                for (int i = pos; i + 1 < table_count; i++)
                    table_slots[i] = table_slots[i + 1];
                table_count--;
            end
        end
        rsp.count = table_count[4:0];
        if (table_count > 0)
        begin
            rsp.front_valid    = 1'b1;
            rsp.front_id       = table_slots[0].task_id;
            rsp.front_deadline = table_slots[0].deadline;
        end
        return rsp;
    endfunction

    function automatic req_t make_insert(logic [31:0] id, logic [31:0] dl, logic kind,
                                         logic [31:0] rel, logic [31:0] fin);
        req_t r;
        r.func        = FUNC_INSERT;
        r.task_id     = id;
        r.deadline    = dl;
        r.task_kind   = kind;
        r.release_at  = rel;
        r.finished_at = fin;
        return r;
    endfunction

    function automatic req_t make_remove(logic [31:0] id);
        req_t r;
        r = make_insert(id, $urandom, 1'($urandom_range(0, 1)), $urandom, $urandom);
        r.func = FUNC_REMOVE;
        return r;
    endfunction

    // random request: well-formed mix with deadlines from a narrow band so
    // equal deadlines happen, sometimes full-range values
    function automatic req_t random_req(int fill_bias);
        logic [31:0] id;
        logic [31:0] dl;
        if ($urandom_range(0, 9) == 0)
            id = $urandom;
        else
            id = id_pool[$urandom_range(0, 7)];
        if ($urandom_range(0, 3) == 0)
            dl = $urandom;
        else
            dl = $urandom_range(0, 12);
        if ($urandom_range(0, 99) < fill_bias)
            return make_insert(id, dl, 1'($urandom_range(0, 1)), $urandom, $urandom);
        else
            return make_remove(id);
    endfunction

    // stimulus: directed corners, then random phases of varying fill pressure
    initial
    begin
        req_t r;
        hold_sender   = 1'b0;
        stimulus_done = 1'b0;
        for (int i = 0; i < 8; i++)
            id_pool[i] = $urandom;
        id_pool[0] = 32'h0;
        id_pool[1] = 32'hFFFF_FFFF;

        // remove from empty queue
        pending_reqs.push_back(make_remove(32'h0));
        // extremes of every field
        pending_reqs.push_back(make_insert(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
                                           32'hFFFF_FFFF, 32'hFFFF_FFFF));
        pending_reqs.push_back(make_insert(32'h0, 32'h0, 1'b0, 32'h0, 32'h0));
        // equal deadlines: newest goes first
        pending_reqs.push_back(make_insert(32'h5, 32'h10, 1'b1, 32'h1, 32'h2));
        pending_reqs.push_back(make_insert(32'h6, 32'h10, 1'b0, 32'h3, 32'h4));
        // duplicate ids: first in table order removed
        pending_reqs.push_back(make_insert(32'h5, 32'h8, 1'b0, 32'h7, 32'h9));
        pending_reqs.push_back(make_remove(32'h5));
        pending_reqs.push_back(make_remove(32'h1234));
        // fill to full and try one more
        for (int i = 0; i < 12; i++)
            pending_reqs.push_back(make_insert(32'h100 + i, $urandom, i[0],
                                               $urandom, $urandom));
        pending_reqs.push_back(make_insert(32'h200, 32'h1, 1'b1, 32'h1, 32'h1));
        // remove the front and back records (the extremes), then task 6
        pending_reqs.push_back(make_remove(32'h0));
        pending_reqs.push_back(make_remove(32'hFFFF_FFFF));
        pending_reqs.push_back(make_remove(32'h6));

        // let the queue drain once before the random part
        wait (pending_reqs.size() == 0 && !in_valid);
        hold_sender = 1'b1;
        wait (expected_rsps.size() == 0);
        hold_sender = 1'b0;

        for (int phase = 0; phase < 11; phase++)
        begin
            int bias;
            bias = (phase % 3 == 0) ? 85 : ((phase % 3 == 1) ? 55 : 25);
            for (int i = 0; i < 50; i++)
            begin
                r = random_req(bias);
                pending_reqs.push_back(r);
            end
            wait (pending_reqs.size() < 4);
        end
        wait (pending_reqs.size() == 0);
        stimulus_done = 1'b1;
    end

    // driver: present the next request at the falling edge, hold while stalled
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_req   <= '0;
        end
        else
        begin
            // a request leaves the channel when it was taken at the last rising edge
            if (in_valid && !in_stall_q)
                in_valid_next_clear = 1'b1;
            if (!in_valid || in_valid_next_clear)
            begin
                in_valid_next_clear = 1'b0;
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (!hold_sender && pending_reqs.size() > 0)
                begin
                    in_req   <= pending_reqs.pop_front();
                    in_valid <= 1'b1;
                    send_gap = pick_gap();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // rising edge: record requests taken by the block and predict the response
    always @(posedge clk)
    begin
        in_stall_q <= in_stall;
        if (rst_n && in_valid && !in_stall)
            expected_rsps.push_back(queue_apply(in_req));
    end

    // receiver stall pattern, changed at the falling edge
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (recv_gap > 0)
        begin
            recv_gap--;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= 1'b0;
            recv_gap = pick_gap();
        end
    end

    // monitor: compare each accepted response with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_rsps.size() == 0)
            begin
                $error("response with no request outstanding");
                error_count++;
            end
            else
            begin : compare
                rsp_t e;
                e = expected_rsps.pop_front();
                if (out_rsp.status !== e.status)
                begin
                    $error("status expected %0d actual %0d", e.status, out_rsp.status);
                    error_count++;
                end
                if (out_rsp.out_id !== e.out_id)
                begin
                    $error("out_id expected %h actual %h", e.out_id, out_rsp.out_id);
                    error_count++;
                end
                if (out_rsp.out_deadline !== e.out_deadline)
                begin
                    $error("out_deadline expected %h actual %h", e.out_deadline,
                           out_rsp.out_deadline);
                    error_count++;
                end
                if (out_rsp.out_kind !== e.out_kind)
                begin
                    $error("out_kind expected %0d actual %0d", e.out_kind, out_rsp.out_kind);
                    error_count++;
                end
                if (out_rsp.out_release !== e.out_release)
                begin
                    $error("out_release expected %h actual %h", e.out_release,
                           out_rsp.out_release);
                    error_count++;
                end
                if (out_rsp.out_finished !== e.out_finished)
                begin
                    $error("out_finished expected %h actual %h", e.out_finished,
                           out_rsp.out_finished);
                    error_count++;
                end
                if (out_rsp.count !== e.count)
                begin
                    $error("count expected %0d actual %0d", e.count, out_rsp.count);
                    error_count++;
                end
                if (out_rsp.front_valid !== e.front_valid)
                begin
                    $error("front_valid expected %0d actual %0d", e.front_valid,
                           out_rsp.front_valid);
                    error_count++;
                end
                if (out_rsp.front_id !== e.front_id)
                begin
                    $error("front_id expected %h actual %h", e.front_id, out_rsp.front_id);
                    error_count++;
                end
                if (out_rsp.front_deadline !== e.front_deadline)
                begin
                    $error("front_deadline expected %h actual %h", e.front_deadline,
                           out_rsp.front_deadline);
                    error_count++;
                end
            end
        end
    end

    // watchdog on total cycles
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= MAX_CYCLES)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // reset, then wait for the traffic to finish and report
    initial
    begin
        error_count         = 0;
        cycle_count         = 0;
        send_gap            = 0;
        recv_gap            = 0;
        in_valid_next_clear = 1'b0;
        in_stall_q          = 1'b1;
        in_valid            = 1'b0;
        in_req              = '0;
        out_stall           = 1'b0;
        rst_n               = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        wait (stimulus_done);
        @(posedge clk);
        while (in_valid || expected_rsps.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (error_count == 0 && !out_valid)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

// ----- files.f -----
hw/rtl/dotq_pkg.sv
hw/rtl/dotq_front.sv
hw/rtl/dotq_back.sv
hw/rtl/deadline_ordered_task_queue_top.sv
sim/tb_deadline_ordered_task_queue_top.sv
